// ----- src/bce_pkg.sv -----
// Shared types and constants for the Bezier curve evaluator.
`default_nettype none
package bce_pkg;
  localparam int MAX_POINTS_DEF = 16;
  localparam int T_FRAC_BITS    = 16;
  localparam logic [16:0] T_ONE = 17'd65536;

  // One queued input item after classification.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
    logic [16:0]        t;
    logic               deriv;
    logic               t_clamped;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_DRAIN,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- src/bce_front.sv -----
// Front end: classify an input item and clamp its parameter.
`default_nettype none
module bce_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic               in_last_point,
  input  wire logic [16:0]        in_curve_param,
  input  wire logic               in_want_derivative,
  output logic                    q_push,
  output bce_pkg::item_t          q_item,
  input  wire logic               q_full
);
  logic over;

  // Clamp t to one and mark the clamp on a last item
  assign over = in_curve_param > bce_pkg::T_ONE;

  always_comb begin
    q_item.x         = in_point_x;
    q_item.y         = in_point_y;
    q_item.z         = in_point_z;
    q_item.last      = in_last_point;
    q_item.t         = over ? bce_pkg::T_ONE : in_curve_param;
    q_item.deriv     = in_want_derivative;
    q_item.t_clamped = in_last_point & over;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid & !q_full;
endmodule
`default_nettype wire

// ----- src/bce_fifo.sv -----
// Two-entry queue between front end and evaluation engine.
`default_nettype none
module bce_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bce_pkg::item_t push_item,
  output logic                full,
  output logic                pop_valid,
  input  wire logic           pop,
  output bce_pkg::item_t      pop_item
);
  bce_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full      = cnt_r == 2'd2;
  assign pop_valid = cnt_r != 2'd0;
  assign do_push   = push & !full;
  assign do_pop    = pop & pop_valid;
  assign pop_item  = mem_r[rp_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ----- src/bce_back.sv -----
// Back end: point store, de Casteljau sequencer and output register.
`default_nettype none
module bce_back #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire bce_pkg::item_t     q_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result_x,
  output logic signed [31:0]      out_result_y,
  output logic signed [31:0]      out_result_z,
  output logic                    out_range_flag
);
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int W    = 33 + IW;
  localparam int DW   = W + 1;
  localparam int PW   = DW + 18;
  localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_POINTS);
  localparam logic [CNTW-1:0] TWO  = CNTW'(2);
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (bce_pkg::T_FRAC_BITS - 1);

  bce_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt, level_r, level_nxt, j_r, j_nxt, n_new;
  logic            drop_r, drop_nxt, tflag_r, tflag_nxt, diff_r, diff_nxt;
  logic            zero_r, zero_nxt;
  logic [16:0]     t_r, t_nxt, m_r, m_nxt;
  logic            store_en, issue;

  logic signed [W-1:0]  w_r [3][MAX_POINTS];
  logic signed [W-1:0]  prev_r [3];
  logic signed [DW-1:0] d1_r [3];
  logic signed [W-1:0]  a1_r [3], a2_r [3];
  logic signed [PW-1:0] p2_r [3];
  logic [IW-1:0]        idx1_r, idx2_r;
  logic                 s1_v_r, s2_v_r;
  logic signed [31:0]   pt [3];
  logic signed [W-1:0]  cur [3];
  logic signed [W-1:0]  wres [3];
  logic signed [31:0]   satv [3];
  logic [2:0]           satf;
  logic signed [17:0]   m_s;

  assign pt[0] = q_item.x;
  assign pt[1] = q_item.y;
  assign pt[2] = q_item.z;
  assign m_s   = signed'({1'b0, m_r});

  // Read operand, finish a lerp or difference, saturate the final value
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k] = w_r[k][j_r[IW-1:0]];
      if (diff_r) begin
        wres[k] = p2_r[k][W-1:0];
      end else begin
        wres[k] = a2_r[k] + W'((p2_r[k] + RND) >>> bce_pkg::T_FRAC_BITS);
      end
      satf[k] = 1'b0;
      satv[k] = w_r[k][0][31:0];
      if (!w_r[k][0][W-1] && (|w_r[k][0][W-2:31])) begin
        satv[k] = 32'sh7fffffff;
        satf[k] = 1'b1;
      end else if (w_r[k][0][W-1] && !(&w_r[k][0][W-2:31])) begin
        satv[k] = 32'sh80000000;
        satf[k] = 1'b1;
      end
    end
  end

  // Next state and sequencer control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    j_nxt     = j_r;
    drop_nxt  = drop_r;
    tflag_nxt = tflag_r;
    diff_nxt  = diff_r;
    zero_nxt  = zero_r;
    t_nxt     = t_r;
    m_nxt     = m_r;
    q_pop     = 1'b0;
    store_en  = 1'b0;
    issue     = 1'b0;
    n_new     = cnt_r;
    unique case (state_r)
      bce_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (cnt_r < MAXC) begin
            store_en = 1'b1;
            n_new    = cnt_r + CNTW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          cnt_nxt = n_new;
          if (q_item.last) begin
            t_nxt     = q_item.t;
            tflag_nxt = q_item.t_clamped;
            level_nxt = n_new;
            j_nxt     = '0;
            zero_nxt  = 1'b0;
            if (n_new < TWO) begin
              zero_nxt  = q_item.deriv;
              state_nxt = bce_pkg::ST_OUT;
            end else if (q_item.deriv) begin
              diff_nxt  = 1'b1;
              m_nxt     = 17'(n_new - CNTW'(1));
              state_nxt = bce_pkg::ST_PASS;
            end else begin
              diff_nxt  = 1'b0;
              m_nxt     = q_item.t;
              state_nxt = bce_pkg::ST_PASS;
            end
          end
        end
      end
      bce_pkg::ST_PASS: begin
        issue = 1'b1;
        j_nxt = j_r + CNTW'(1);
        if (j_r == level_r - CNTW'(1)) begin
          state_nxt = bce_pkg::ST_DRAIN;
        end
      end
      bce_pkg::ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          level_nxt = level_r - CNTW'(1);
          diff_nxt  = 1'b0;
          m_nxt     = t_r;
          j_nxt     = '0;
          if (level_r - CNTW'(1) < TWO) begin
            state_nxt = bce_pkg::ST_OUT;
          end else begin
            state_nxt = bce_pkg::ST_PASS;
          end
        end
      end
      bce_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = bce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bce_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bce_pkg::ST_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      s1_v_r  <= issue && (j_r != '0);
      s2_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    j_r     <= j_nxt;
    tflag_r <= tflag_nxt;
    diff_r  <= diff_nxt;
    zero_r  <= zero_nxt;
    t_r     <= t_nxt;
    m_r     <= m_nxt;
  end

  // Datapath: store, subtract, multiply, write back
  always_ff @(posedge clk) begin
    idx1_r <= IW'(j_r - CNTW'(1));
    idx2_r <= idx1_r;
    for (int k = 0; k < 3; k++) begin
      if (store_en) begin
        w_r[k][cnt_r[IW-1:0]] <= W'(pt[k]);
      end else if (s2_v_r) begin
        w_r[k][idx2_r] <= wres[k];
      end
      if (issue) begin
        prev_r[k] <= cur[k];
      end
      d1_r[k] <= DW'(cur[k]) - DW'(prev_r[k]);
      a1_r[k] <= prev_r[k];
      p2_r[k] <= PW'(d1_r[k]) * PW'(m_s);
      a2_r[k] <= a1_r[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == bce_pkg::ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bce_pkg::ST_OUT && (!out_valid || out_ready)) begin
      out_result_x   <= zero_r ? 32'sd0 : satv[0];
      out_result_y   <= zero_r ? 32'sd0 : satv[1];
      out_result_z   <= zero_r ? 32'sd0 : satv[2];
      out_range_flag <= drop_r | tflag_r | (!zero_r & (|satf));
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXC) else $error("point count above capacity");
  a_pass_level: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bce_pkg::ST_PASS |-> level_r >= TWO) else $error("pass on short level");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bce_pkg::ST_IDLE |-> !s1_v_r && !s2_v_r) else $error("pipeline busy in idle");
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r)) else $error("pipeline stage skipped");
`endif
endmodule
`default_nettype wire

// ----- src/bezier_curve_evaluator.sv -----
// Top level of the de Casteljau Bezier curve evaluator.
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | point xyz, last_point, curve_param, derivative
//   out_    | output    | out_valid / out_ready | result xyz, range_flag
// A point item is popped from the two-entry queue while the back is idle and stored if room.
// A last item runs one pass for each level L from n down to 2 through the shared
// subtract-multiply-add pipeline, then loads the output register; in derivative mode the
// pass at level n forms the scaled differences and the lerps run from n-1 down to 2.
// Reset is synchronous: queue, count and sequencer clear; the point store needs none.
// The front keeps accepting while the queue has room; a held result stalls only the back.
`default_nettype none
module bezier_curve_evaluator #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic               in_last_point,
  input  wire logic [16:0]        in_curve_param,
  input  wire logic               in_want_derivative,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result_x,
  output logic signed [31:0]      out_result_y,
  output logic signed [31:0]      out_result_z,
  output logic                    out_range_flag
);
  bce_pkg::item_t push_item, pop_item;
  logic push, full, pop_valid, pop;

  bce_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_point_z         (in_point_z),
    .in_last_point      (in_last_point),
    .in_curve_param     (in_curve_param),
    .in_want_derivative (in_want_derivative),
    .q_push             (push),
    .q_item             (push_item),
    .q_full             (full)
  );

  bce_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  bce_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_pop          (pop),
    .q_item         (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_x   (out_result_x),
    .out_result_y   (out_result_y),
    .out_result_z   (out_result_z),
    .out_range_flag (out_range_flag)
  );
endmodule
`default_nettype wire
